[sv/dmppe_pkg.sv]
// Package with the shared types and constants of the disc meter pulse, power and energy block.
package dmppe_pkg;

    localparam int DIV_W = 49;
    localparam int DEN_W = 48;

    localparam logic [38:0] CW_PER_ROT_MS = 39'd360000000000;
    localparam logic [16:0] CWH_PER_KWH   = 17'd100000;

    localparam logic [2:0] REG_THRESHOLD   = 3'd0;
    localparam logic [2:0] REG_OFF_TOL     = 3'd1;
    localparam logic [2:0] REG_ON_TOL      = 3'd2;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd3;
    localparam logic [2:0] REG_ROT_PER_KWH = 3'd4;
    localparam logic [2:0] REG_CAL_MODE    = 3'd5;
    localparam logic [2:0] REG_MIN_SPAN    = 3'd6;
    localparam logic [2:0] REG_CAPTURE     = 3'd7;

    localparam logic [1:0] CMD_ANALOG  = 2'd0;
    localparam logic [1:0] CMD_DIGITAL = 2'd1;
    localparam logic [1:0] CMD_CAL     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PMUL,
        S_PSTART,
        S_PWAIT,
        S_EMUL,
        S_ESTART,
        S_EWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[sv/disc_meter_pulse_power_energy.sv]
// Top level of the disc meter pulse, power and energy block.
//
// Items arrive on the s_axis channel: tuser carries the command (analog
// sample, digital level or calibration start) and tdata the sample, the
// digital level and the millisecond timestamp. Each accepted beat gives
// exactly one result beat on the m_axis channel with the qualified level,
// the rotation flags, power, rotation count, energy and calibration status.
// Configuration registers are written and read through the APB-style port;
// pready is always high and register i lies at byte address 4*i.
// The comparator, debounce and calibration updates are settled in the cycle
// the beat is accepted. A shared restoring divider then computes the power
// (only on a counted rotation) and the energy after a registered multiply;
// each division runs 49 quotient steps. The next input beat is taken only
// after the previous result has gone to the output register; s_axis_tready
// is high only while the sequencer is idle.
// The result sits in an output register, so the sequencer returns to idle
// while a result waits; it holds the next result until the receiver takes
// the previous one. A synchronous reset loads the register reset values,
// clears all edge and rotation state and leaves calibration idle.
module disc_meter_pulse_power_energy
    import dmppe_pkg::*;
#(
    parameter int MAX_CAL_ROUNDS = 3
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, lowest bit up: sample[15:0], digital_level[16], time_ms[48:17]
    input  logic [55:0]  s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, lowest bit up: level[0], rotation_seen[1], edge_rejected[2],
    // power_cw[41:3], rotation_count[73:42], energy_cwh[122:74],
    // cal_running[123], cal_done[124], cal_failed[125], cal_span[141:126],
    // threshold_in_use[157:142]
    output logic [159:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [1:0] MAX_ROUNDS = 2'(MAX_CAL_ROUNDS);

    // Configuration registers.
    logic [15:0] r_threshold, r_off_tol, r_on_tol, r_debounce, r_rpk, r_min_span, r_capture;
    logic        r_cal_mode;

    // Block state.
    logic        r_last_level, n_last_level;
    logic [31:0] r_edge_time, n_edge_time;
    logic        r_edge_valid, n_edge_valid;
    logic [31:0] r_rise_time, n_rise_time;
    logic        r_rise_valid, n_rise_valid;
    logic [31:0] r_total, n_total;
    logic [15:0] r_cal_cnt, n_cal_cnt;
    logic [1:0]  r_cal_round, n_cal_round;
    logic [15:0] r_max, n_max;
    logic [15:0] r_min, n_min;
    logic [15:0] r_act_thr, n_act_thr;

    // Per-item results held until the output beat is built.
    logic        r_seen, n_seen;
    logic        r_rej, n_rej;
    logic        r_done, n_done;
    logic        r_fail, n_fail;
    logic [15:0] r_span, n_span;
    logic [31:0] r_period, n_period;
    logic [38:0] r_power;
    logic [48:0] r_energy;

    logic [DIV_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;

    t_state r_state, n_state;
    logic   r_ovalid;
    logic [159:0] r_odata;

    logic        div_start;
    t_div_stat   div_stat;
    logic [DIV_W-1:0] div_quo;

    logic        accept, cfg_wr;
    logic [1:0]  cmd;
    logic [15:0] smp;
    logic        dig;
    logic [31:0] now;
    logic [16:0] hi_bound;
    logic [15:0] bound;
    logic        lvl;
    logic [15:0] rpk_nz;
    logic [15:0] cnt_inc;
    logic [15:0] span_val;
    logic [16:0] mid_sum;
    logic [31:0] low_time;
    logic [31:0] per_raw;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cmd    = s_axis_tuser;
    assign smp    = s_axis_tdata[15:0];
    assign dig    = s_axis_tdata[16];
    assign now    = s_axis_tdata[48:17];
    assign rpk_nz = (r_rpk == 16'd0) ? 16'd1 : r_rpk;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[4:2])
            REG_THRESHOLD:   prdata = {16'd0, r_threshold};
            REG_OFF_TOL:     prdata = {16'd0, r_off_tol};
            REG_ON_TOL:      prdata = {16'd0, r_on_tol};
            REG_DEBOUNCE:    prdata = {16'd0, r_debounce};
            REG_ROT_PER_KWH: prdata = {16'd0, r_rpk};
            REG_CAL_MODE:    prdata = {31'd0, r_cal_mode};
            REG_MIN_SPAN:    prdata = {16'd0, r_min_span};
            REG_CAPTURE:     prdata = {16'd0, r_capture};
            default:         prdata = 32'd0;
        endcase
    end

    // Item update: comparator, edge qualification and calibration tracking.
    always_comb begin
        n_last_level = r_last_level;
        n_edge_time  = r_edge_time;
        n_edge_valid = r_edge_valid;
        n_rise_time  = r_rise_time;
        n_rise_valid = r_rise_valid;
        n_total      = r_total;
        n_cal_cnt    = r_cal_cnt;
        n_cal_round  = r_cal_round;
        n_max        = r_max;
        n_min        = r_min;
        n_act_thr    = r_act_thr;
        n_seen       = r_seen;
        n_rej        = r_rej;
        n_done       = r_done;
        n_fail       = r_fail;
        n_span       = r_span;
        n_period     = r_period;

        // The high bound saturates at full scale, the low bound at zero.
        hi_bound = {1'b0, r_act_thr} + {1'b0, r_on_tol};
        if (r_last_level) begin
            bound = (r_act_thr >= r_off_tol) ? (r_act_thr - r_off_tol) : 16'd0;
        end else begin
            bound = hi_bound[16] ? 16'hFFFF : hi_bound[15:0];
        end
        lvl      = (cmd == CMD_ANALOG) ? (smp > bound) : dig;
        low_time = now - r_edge_time;
        per_raw  = now - r_rise_time;
        cnt_inc  = r_cal_cnt + 16'd1;
        span_val = 16'd0;
        mid_sum  = 17'd0;

        if (accept) begin
            n_seen = 1'b0;
            n_rej  = 1'b0;
            n_done = 1'b0;
            n_fail = 1'b0;
            n_span = 16'd0;
            if ((cmd == CMD_ANALOG || cmd == CMD_DIGITAL) && lvl != r_last_level) begin
                if (!r_cal_mode) begin
                    if (lvl) begin
                        if (!r_rise_valid) begin
                            // The first rising edge only leaves its time stamp.
                            n_rise_time  = now;
                            n_rise_valid = 1'b1;
                        end else if (r_edge_valid && low_time < {16'd0, r_debounce}) begin
                            n_rej = 1'b1;
                        end else begin
                            n_seen      = 1'b1;
                            n_period    = (per_raw == 32'd0) ? 32'd1 : per_raw;
                            n_rise_time = now;
                            if (r_total != 32'hFFFF_FFFF) begin
                                n_total = r_total + 32'd1;
                            end
                        end
                    end
                    n_edge_time  = now;
                    n_edge_valid = 1'b1;
                end
                n_last_level = lvl;
            end

            if (cmd == CMD_ANALOG && r_cal_cnt < r_capture) begin
                if (r_cal_cnt == 16'd0) begin
                    n_cal_round = r_cal_round + 2'd1;
                    n_max       = smp;
                    n_min       = smp;
                end else begin
                    if (smp > r_max) n_max = smp;
                    if (smp < r_min) n_min = smp;
                end
                n_cal_cnt = cnt_inc;
                if (cnt_inc == r_capture) begin
                    span_val = n_max - n_min;
                    mid_sum  = {1'b0, n_min} + {1'b0, n_max};
                    if (span_val >= r_min_span) begin
                        n_act_thr = mid_sum[16:1];
                        n_done    = 1'b1;
                        n_span    = span_val;
                    end else if (n_cal_round < MAX_ROUNDS) begin
                        n_cal_cnt = 16'd0;
                    end else begin
                        n_done = 1'b1;
                        n_fail = 1'b1;
                        n_span = span_val;
                    end
                end
            end else if (cmd == CMD_CAL) begin
                n_cal_cnt   = 16'd0;
                n_cal_round = 2'd0;
            end
        end

        // Side effects of configuration writes.
        if (cfg_wr) begin
            if (paddr[4:2] == REG_THRESHOLD) begin
                n_act_thr = pwdata[15:0];
            end
            if (paddr[4:2] == REG_CAL_MODE && pwdata[0]) begin
                n_edge_valid = 1'b0;
                n_rise_valid = 1'b0;
                n_edge_time  = 32'd0;
                n_rise_time  = 32'd0;
            end
            if (paddr[4:2] == REG_CAPTURE) begin
                n_cal_cnt = pwdata[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 16'd0;
            r_off_tol   <= 16'd0;
            r_on_tol    <= 16'd0;
            r_debounce  <= 16'd0;
            r_rpk       <= 16'd75;
            r_cal_mode  <= 1'b0;
            r_min_span  <= 16'd6;
            r_capture   <= 16'd6000;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_THRESHOLD:   r_threshold <= pwdata[15:0];
                REG_OFF_TOL:     r_off_tol   <= pwdata[15:0];
                REG_ON_TOL:      r_on_tol    <= pwdata[15:0];
                REG_DEBOUNCE:    r_debounce  <= pwdata[15:0];
                REG_ROT_PER_KWH: r_rpk       <= pwdata[15:0];
                REG_CAL_MODE:    r_cal_mode  <= pwdata[0];
                REG_MIN_SPAN:    r_min_span  <= pwdata[15:0];
                REG_CAPTURE:     r_capture   <= pwdata[15:0];
                default:         r_cal_mode  <= r_cal_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_edge_time  <= 32'd0;
            r_edge_valid <= 1'b0;
            r_rise_time  <= 32'd0;
            r_rise_valid <= 1'b0;
            r_total      <= 32'd0;
            r_cal_cnt    <= 16'd6000;
            r_cal_round  <= 2'd0;
            r_max        <= 16'd0;
            r_min        <= 16'd0;
            r_act_thr    <= 16'd0;
            r_seen       <= 1'b0;
            r_rej        <= 1'b0;
            r_done       <= 1'b0;
            r_fail       <= 1'b0;
        end else begin
            r_last_level <= n_last_level;
            r_edge_time  <= n_edge_time;
            r_edge_valid <= n_edge_valid;
            r_rise_time  <= n_rise_time;
            r_rise_valid <= n_rise_valid;
            r_total      <= n_total;
            r_cal_cnt    <= n_cal_cnt;
            r_cal_round  <= n_cal_round;
            r_max        <= n_max;
            r_min        <= n_min;
            r_act_thr    <= n_act_thr;
            r_seen       <= n_seen;
            r_rej        <= n_rej;
            r_done       <= n_done;
            r_fail       <= n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_span   <= n_span;
        r_period <= n_period;
    end

    // Sequencer around the shared divider.
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = n_seen ? S_PMUL : S_EMUL;
            S_PMUL:   n_state = S_PSTART;
            S_PSTART: begin
                div_start = 1'b1;
                n_state   = S_PWAIT;
            end
            S_PWAIT:  if (div_stat.done) n_state = S_EMUL;
            S_EMUL:   n_state = S_ESTART;
            S_ESTART: begin
                div_start = 1'b1;
                n_state   = S_EWAIT;
            end
            S_EWAIT:  if (div_stat.done) n_state = S_OUT;
            S_OUT:    if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_power <= 39'd0;
        end
        if (r_state == S_PMUL) begin
            r_num <= {10'd0, CW_PER_ROT_MS};
            r_den <= r_period * rpk_nz;
        end
        if (r_state == S_PWAIT && div_stat.done) begin
            r_power <= div_quo[38:0];
        end
        if (r_state == S_EMUL) begin
            r_num <= r_total * CWH_PER_KWH;
            r_den <= {32'd0, rpk_nz};
        end
        if (r_state == S_EWAIT && div_stat.done) begin
            r_energy <= div_quo;
        end
    end

    dmppe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // Output register: the result beat waits here while the block goes idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
            r_odata <= {2'b00, r_act_thr, r_span, r_fail, r_done,
                        (r_cal_cnt < r_capture), r_energy, r_total, r_power,
                        r_rej, r_seen, r_last_level};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef ASSERT_OFF
    a_seen_not_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
        else $error("rotation counted and rejected on the same beat");
    a_fail_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[125] |-> m_axis_tdata[124])
        else $error("calibration failure reported without done");
    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_PWAIT || r_state == S_EWAIT))
        else $error("divider finished outside a wait state");
    a_start_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");
`endif

endmodule

[sv/dmppe_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module dmppe_div
    import dmppe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output t_div_stat          o_stat,
    output logic [DIV_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(DIV_W);

    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        fits  = trial >= {2'b00, r_den};
        n_rem = fits ? DIV_W'(trial - {2'b00, r_den}) : trial[DIV_W-1:0];
        n_quo = {r_quo[DIV_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule
